@@ hdl/mfog_pkg.sv @@
// ---------------------------------------------------------------------------
// mfog_pkg
// Shared types, widths and codes of the matrix fill order generator.
// ---------------------------------------------------------------------------
`default_nettype none

package mfog_pkg;

    localparam int MAX_SIZE  = 64;
    localparam int IDX_W     = 6;   // row / column index
    localparam int SIZE_W    = 7;   // side length register
    localparam int DIAG_W    = 7;   // anti-diagonal number, up to 2n-1
    localparam int COUNT_W   = 13;  // fill number, up to n*n
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 7;

    localparam logic [MODE_W-1:0] MODE_COLUMN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SNAKE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIAG   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPIRAL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FILL_MODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 8'd1;

    localparam logic [MODE_W-1:0]  RESET_MODE = MODE_COLUMN;
    localparam logic [SIZE_W-1:0]  RESET_SIZE = 7'd4;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [COUNT_W-1:0] count;
        dir_t               dir;
        logic [DIAG_W-1:0]  diag;
        logic [IDX_W-1:0]   top;
        logic [IDX_W-1:0]   bottom;
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
    } walk_t;

    // Clamp the programmed size into 1..MAX_SIZE.
    function automatic logic [SIZE_W-1:0] side(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        n = size;
        if (n == '0) begin
            n = SIZE_W'(1);
        end else if (n > SIZE_W'(MAX_SIZE)) begin
            n = SIZE_W'(MAX_SIZE);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hdl/matrix_fill_order_generator_core.sv @@
// ---------------------------------------------------------------------------
// matrix_fill_order_generator_core
// Cell order generator for filling an n by n matrix in one of four orders.
// ---------------------------------------------------------------------------
// Usage:
//   Each word on the s_ channel (s_tdata bit 0 = restart) asks for one cell.
//   restart = 1 returns the first cell of the order, 0 advances one cell;
//   after the final cell the order wraps to the first cell again.
//   Each request gives one word on the m_ channel: row, column and running
//   fill number in m_tdata, m_tlast set on the final cell (fill number n*n).
//   The cfg channel writes fill_mode (index 0) and matrix_size (index 1);
//   any write restarts the order, other indexes are ignored. cfg_ready is
//   high only while no request is in flight.
// Timing:
//   A request passes through the input register, then the next-cell compares
//   write into the state/result register, which drives the result. One cell
//   per clock sustained while m_tready is high; while m_tready is low the
//   result holds, the input register takes one more word and then s_tready drops.
// Reset:
//   aresetn low clears both stages, sets fill_mode to 0 and matrix_size to
//   4; the first request after reset gives the first cell.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_fill_order_generator_core
    import mfog_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,     // [0] restart, [7:1] zero

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,     // [5:0] row, [11:6] col,
                                                   // [24:12] fill_value, [31:25] zero
    output logic                      m_tlast,     // last

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic [MODE_W-1:0]  fill_mode_reg;
    logic [SIZE_W-1:0]  matrix_size_reg;
    logic               in_valid_reg;
    logic               in_restart_reg;
    logic               out_valid_reg;
    logic               last_reg;
    walk_t              walk_reg;
    walk_t              walk_next;
    logic               last_next;
    logic [SIZE_W-1:0]  n;
    logic [COUNT_W-1:0] total;
    logic               advance;
    logic               fire;
    logic               s_accept;
    logic               cfg_accept;

    assign n     = side(matrix_size_reg);
    assign total = COUNT_W'(n) * COUNT_W'(n);

    assign advance    = !out_valid_reg || m_tready;
    assign fire       = in_valid_reg && advance;
    assign s_tready   = !in_valid_reg || advance;
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = !in_valid_reg && !out_valid_reg;
    assign cfg_accept = cfg_valid && cfg_ready;

    mfog_step u_step (
        .cur     (walk_reg),
        .mode    (fill_mode_reg),
        .n       (n),
        .total   (total),
        .restart (in_restart_reg),
        .nxt     (walk_next),
        .last    (last_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_mode_reg   <= RESET_MODE;
            matrix_size_reg <= RESET_SIZE;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            walk_reg.count  <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= 1'b1;
                walk_reg      <= walk_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_accept) begin
                case (cfg_index)
                    REG_FILL_MODE: begin
                        fill_mode_reg  <= cfg_data[MODE_W-1:0];
                        walk_reg.count <= '0;
                    end
                    REG_MATRIX_SIZE: begin
                        matrix_size_reg <= cfg_data;
                        walk_reg.count  <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_restart_reg <= s_tdata[0];
        end
        if (fire) begin
            last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, walk_reg.count, walk_reg.col, walk_reg.row};
    assign m_tlast  = last_reg;

    // A waiting request moves into an empty result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("request did not advance into empty result stage");

    // The final-cell mark goes with fill number n*n and nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (last_reg == (walk_reg.count == total)))
        else $error("last mark disagrees with fill number");

    // A delivered cell lies inside the matrix and has a fill number in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ({1'b0, walk_reg.row} < n) && ({1'b0, walk_reg.col} < n)
                          && (walk_reg.count != '0) && (walk_reg.count <= total))
        else $error("cell outside matrix or fill number out of range");

endmodule

`default_nettype wire

@@ hdl/mfog_step.sv @@
// ---------------------------------------------------------------------------
// mfog_step
// Next-cell logic: from the current walk state, mode and size, form the
// state of the next cell in the fill order.
// ---------------------------------------------------------------------------
`default_nettype none

module mfog_step
    import mfog_pkg::*;
(
    input  var walk_t              cur,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [SIZE_W-1:0] n,
    input  wire logic [COUNT_W-1:0] total,
    input  wire logic              restart,
    output var walk_t              nxt,
    output logic                   last
);

    logic [SIZE_W-1:0] row_inc;
    logic [SIZE_W-1:0] col_inc;
    logic [DIAG_W-1:0] diag_inc;
    logic [IDX_W-1:0]  n_m1;
    logic              row_lt;
    logic              col_lt;
    logic              first;

    assign row_inc  = {1'b0, cur.row} + SIZE_W'(1);
    assign col_inc  = {1'b0, cur.col} + SIZE_W'(1);
    assign diag_inc = cur.diag + DIAG_W'(1);
    assign n_m1     = IDX_W'(n - SIZE_W'(1));
    assign row_lt   = row_inc < n;
    assign col_lt   = col_inc < n;
    assign first    = restart || (cur.count == '0) || (cur.count >= total);

    always_comb begin
        nxt = cur;
        if (first) begin
            nxt.row    = (mode == MODE_DIAG) ? n_m1 : '0;
            nxt.col    = '0;
            nxt.count  = COUNT_W'(1);
            nxt.dir    = DIR_DOWN;
            nxt.diag   = DIAG_W'(1);
            nxt.top    = '0;
            nxt.bottom = n_m1;
            nxt.left   = '0;
            nxt.right  = n_m1;
        end else begin
            nxt.count = cur.count + COUNT_W'(1);
            case (mode)
                MODE_COLUMN: begin
                    if (row_lt) begin
                        nxt.row = cur.row + IDX_W'(1);
                    end else begin
                        nxt.row = '0;
                        nxt.col = cur.col + IDX_W'(1);
                    end
                end
                MODE_SNAKE: begin
                    if (cur.dir == DIR_DOWN && row_lt) begin
                        nxt.row = cur.row + IDX_W'(1);
                    end else if (cur.dir != DIR_DOWN && cur.row != '0) begin
                        nxt.row = cur.row - IDX_W'(1);
                    end else begin
                        nxt.col = cur.col + IDX_W'(1);
                        nxt.dir = (cur.dir == DIR_DOWN) ? DIR_UP : DIR_DOWN;
                    end
                end
                MODE_DIAG: begin
                    if (row_lt && col_lt) begin
                        nxt.row = cur.row + IDX_W'(1);
                        nxt.col = cur.col + IDX_W'(1);
                    end else begin
                        // open the next anti-diagonal on the left edge or the top edge
                        nxt.diag = diag_inc;
                        if (diag_inc < n) begin
                            nxt.row = IDX_W'(n - diag_inc);
                            nxt.col = '0;
                        end else begin
                            nxt.row = '0;
                            nxt.col = IDX_W'(diag_inc - n);
                        end
                    end
                end
                default: begin
                    case (cur.dir)
                        DIR_DOWN: begin
                            if (cur.row < cur.bottom) begin
                                nxt.row = cur.row + IDX_W'(1);
                            end else begin
                                nxt.left = cur.left + IDX_W'(1);
                                nxt.dir  = DIR_RIGHT;
                                nxt.col  = cur.col + IDX_W'(1);
                            end
                        end
                        DIR_RIGHT: begin
                            if (cur.col < cur.right) begin
                                nxt.col = cur.col + IDX_W'(1);
                            end else begin
                                nxt.bottom = cur.bottom - IDX_W'(1);
                                nxt.dir    = DIR_UP;
                                nxt.row    = cur.row - IDX_W'(1);
                            end
                        end
                        DIR_UP: begin
                            if (cur.row > cur.top) begin
                                nxt.row = cur.row - IDX_W'(1);
                            end else begin
                                nxt.right = cur.right - IDX_W'(1);
                                nxt.dir   = DIR_LEFT;
                                nxt.col   = cur.col - IDX_W'(1);
                            end
                        end
                        default: begin
                            if (cur.col > cur.left) begin
                                nxt.col = cur.col - IDX_W'(1);
                            end else begin
                                nxt.top = cur.top + IDX_W'(1);
                                nxt.dir = DIR_DOWN;
                                nxt.row = cur.row + IDX_W'(1);
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    assign last = (nxt.count == total);

endmodule

`default_nettype wire

@@ bench/fill_order_checker.sv @@
// ---------------------------------------------------------------------------
// fill_order_checker
// Watches the request, result and register channels of the fill order
// generator, predicts each cell and compares it with the result stream.
// ---------------------------------------------------------------------------
module fill_order_checker
    import mfog_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   error_count,
    output int                   result_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [COUNT_W-1:0] fill;
        logic               last;
    } cell_t;

    // programmed registers
    logic [MODE_W-1:0]  fill_mode;
    logic [SIZE_W-1:0]  matrix_size;

    // walk state of the predictor
    logic [IDX_W-1:0]   walk_row;
    logic [IDX_W-1:0]   walk_col;
    logic [COUNT_W-1:0] walk_count;
    dir_t               walk_dir;
    logic [DIAG_W-1:0]  walk_diag;
    logic [IDX_W-1:0]   bound_top;
    logic [IDX_W-1:0]   bound_bottom;
    logic [IDX_W-1:0]   bound_left;
    logic [IDX_W-1:0]   bound_right;

    cell_t              expected_cells[$];
    int                 mismatches;
    int                 results_seen;

    function automatic logic [SIZE_W-1:0] clamp_side();
        logic [SIZE_W-1:0] n;
        n = matrix_size;
        if (n == '0) begin
            n = SIZE_W'(1);
        end else if (n > SIZE_W'(MAX_SIZE)) begin
            n = SIZE_W'(MAX_SIZE);
        end
        return n;
    endfunction

    function automatic void clear_walk();
        logic [SIZE_W-1:0] n;
        n = clamp_side();
        walk_row     = '0;
        walk_col     = '0;
        walk_count   = '0;
        walk_dir     = DIR_DOWN;
        walk_diag    = DIAG_W'(1);
        bound_top    = '0;
        bound_bottom = IDX_W'(n - SIZE_W'(1));
        bound_left   = '0;
        bound_right  = IDX_W'(n - SIZE_W'(1));
    endfunction

    function automatic void advance_cell(input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] row_up;
        logic [SIZE_W-1:0] col_up;
        row_up = {1'b0, walk_row} + SIZE_W'(1);
        col_up = {1'b0, walk_col} + SIZE_W'(1);
        case (fill_mode)
            MODE_COLUMN: begin
                if (row_up < n) begin
                    walk_row = walk_row + 1'b1;
                end else begin
                    walk_row = '0;
                    walk_col = walk_col + 1'b1;
                end
            end
            MODE_SNAKE: begin
                if (walk_dir == DIR_DOWN && row_up < n) begin
                    walk_row = walk_row + 1'b1;
                end else if (walk_dir != DIR_DOWN && walk_row != '0) begin
                    walk_row = walk_row - 1'b1;
                end else begin
                    walk_col = walk_col + 1'b1;
                    walk_dir = (walk_dir == DIR_DOWN) ? DIR_UP : DIR_DOWN;
                end
            end
            MODE_DIAG: begin
                if (row_up < n && col_up < n) begin
                    walk_row = walk_row + 1'b1;
                    walk_col = walk_col + 1'b1;
                end else begin
                    walk_diag = walk_diag + 1'b1;
                    if (walk_diag < n) begin
                        walk_row = IDX_W'(n - walk_diag);
                        walk_col = '0;
                    end else begin
                        walk_row = '0;
                        walk_col = IDX_W'(walk_diag - n);
                    end
                end
            end
            default: begin
                case (walk_dir)
                    DIR_DOWN: begin
                        if (walk_row < bound_bottom) begin
                            walk_row = walk_row + 1'b1;
                        end else begin
                            bound_left = bound_left + 1'b1;
                            walk_dir   = DIR_RIGHT;
                            walk_col   = walk_col + 1'b1;
                        end
                    end
                    DIR_RIGHT: begin
                        if (walk_col < bound_right) begin
                            walk_col = walk_col + 1'b1;
                        end else begin
                            bound_bottom = bound_bottom - 1'b1;
                            walk_dir     = DIR_UP;
                            walk_row     = walk_row - 1'b1;
                        end
                    end
                    DIR_UP: begin
                        if (walk_row > bound_top) begin
                            walk_row = walk_row - 1'b1;
                        end else begin
                            bound_right = bound_right - 1'b1;
                            walk_dir    = DIR_LEFT;
                            walk_col    = walk_col - 1'b1;
                        end
                    end
                    default: begin
                        if (walk_col > bound_left) begin
                            walk_col = walk_col - 1'b1;
                        end else begin
                            bound_top = bound_top + 1'b1;
                            walk_dir  = DIR_DOWN;
                            walk_row  = walk_row + 1'b1;
                        end
                    end
                endcase
            end
        endcase
        walk_count = walk_count + 1'b1;
    endfunction

    // Compute the cell that one request produces and advance the walk.
    function automatic cell_t next_cell(input logic restart);
        logic [SIZE_W-1:0]  n;
        logic [COUNT_W-1:0] total;
        cell_t              c;
        n     = clamp_side();
        total = COUNT_W'(n) * COUNT_W'(n);
        if (restart || walk_count == '0 || walk_count >= total) begin
            clear_walk();
            if (fill_mode == MODE_DIAG) begin
                walk_row = IDX_W'(n - SIZE_W'(1));
            end
            walk_count = COUNT_W'(1);
        end else begin
            advance_cell(n);
        end
        c.row  = walk_row;
        c.col  = walk_col;
        c.fill = walk_count;
        c.last = (walk_count == total);
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge aclk) begin
        cell_t want;
        cell_t got;
        if (!aresetn) begin
            fill_mode   = RESET_MODE;
            matrix_size = RESET_SIZE;
            clear_walk();
            expected_cells.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                // unknown indexes leave the walk untouched
                if (cfg_index == REG_FILL_MODE) begin
                    fill_mode = cfg_data[MODE_W-1:0];
                    clear_walk();
                end else if (cfg_index == REG_MATRIX_SIZE) begin
                    matrix_size = cfg_data;
                    clear_walk();
                end
            end
            if (m_tvalid && m_tready) begin
                got.row  = m_tdata[5:0];
                got.col  = m_tdata[11:6];
                got.fill = m_tdata[24:12];
                got.last = m_tlast;
                results_seen++;
                if (expected_cells.size() == 0) begin
                    report_mismatch($sformatf("unexpected word row %0d col %0d fill %0d",
                                              got.row, got.col, got.fill));
                end else begin
                    want = expected_cells.pop_front();
                    if (got.row != want.row || got.col != want.col ||
                        got.fill != want.fill || got.last != want.last) begin
                        report_mismatch($sformatf(
                            "row %0d/%0d col %0d/%0d fill %0d/%0d last %0b/%0b (got/exp)",
                            got.row, want.row, got.col, want.col,
                            got.fill, want.fill, got.last, want.last));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_cells.push_back(next_cell(s_tdata[0]));
            end
        end
        error_count  <= mismatches;
        result_count <= results_seen;
        outstanding  <= expected_cells.size();
    end

endmodule

@@ bench/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Regression bench for the matrix fill order generator: directed corner
// cells, then random mode/size phases, with random back-pressure on the result
// channel and random request gaps, all results checked by fill_order_checker.
// ---------------------------------------------------------------------------
module tb_top;
    import mfog_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [0] restart, [7:1] zero
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;    // [5:0] row, [11:6] col, [24:12] fill_value
    logic                 m_tlast;    // last
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int                   error_count;
    int                   result_count;
    int                   outstanding;
    int                   cycles;
    int                   requests;
    int                   reg_writes;
    logic                 steady;

    matrix_fill_order_generator_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fill_order_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .result_count (result_count),
        .outstanding  (outstanding)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, outstanding);
            $display("matrix_fill_order_generator_core regression: fail");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 23);
    end

    task automatic request_cell(input logic restart);
        while (!steady && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests++;
    endtask

    // Write a register once every requested cell has come back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic run_cells(input int count);
        for (int i = 0; i < count; i++) begin
            request_cell($urandom_range(99) < 4);
        end
    endtask

    initial begin
        int                phase;
        int                pick;
        int                side_n;
        int                run_len;
        logic [SIZE_W-1:0] size_val;

        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        steady     <= 1'b0;
        requests   = 0;
        reg_writes = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: first cell without restart, advance, then restart
        request_cell(1'b0);
        request_cell(1'b0);
        request_cell(1'b0);
        request_cell(1'b1);
        // single-cell anti-diagonal
        write_reg(REG_MATRIX_SIZE, 7'd1);
        write_reg(REG_FILL_MODE, CFG_DAT_W'(MODE_DIAG));
        request_cell(1'b0);
        request_cell(1'b1);
        request_cell(1'b0);
        // zero size acts as one
        write_reg(REG_MATRIX_SIZE, 7'd0);
        request_cell(1'b0);
        request_cell(1'b0);
        // oversize saturates to the largest matrix
        write_reg(REG_MATRIX_SIZE, 7'd127);
        write_reg(REG_FILL_MODE, CFG_DAT_W'(MODE_SPIRAL));
        request_cell(1'b0);
        request_cell(1'b0);
        request_cell(1'b1);
        // unknown indexes must not restart the walk
        write_reg(8'd2, 7'd5);
        write_reg(8'hFF, 7'd3);
        request_cell(1'b0);
        request_cell(1'b0);
        // small spiral through the wrap
        write_reg(REG_MATRIX_SIZE, 7'd2);
        request_cell(1'b0);
        request_cell(1'b0);
        request_cell(1'b0);
        request_cell(1'b0);
        request_cell(1'b0);
        write_reg(REG_FILL_MODE, CFG_DAT_W'(MODE_SNAKE));
        write_reg(REG_MATRIX_SIZE, 7'd64);
        request_cell(1'b0);
        request_cell(1'b0);

        // random phases: mostly small matrices walked through the wrap
        phase = 0;
        while (requests < RANDOM_ITEMS + 21) begin
            s_tvalid <= 1'b0;
            steady   <= (phase == 6 || phase == 7);
            pick = $urandom_range(99);
            if (pick < 70) begin
                size_val = SIZE_W'($urandom_range(1, 8));
            end else if (pick < 85) begin
                size_val = SIZE_W'($urandom_range(9, 20));
            end else if (pick < 93) begin
                size_val = SIZE_W'($urandom_range(21, 64));
            end else if (pick < 97) begin
                size_val = '0;
            end else begin
                size_val = SIZE_W'($urandom_range(65, 127));
            end
            side_n = (size_val == 0) ? 1 : (size_val > MAX_SIZE) ? MAX_SIZE : size_val;
            if ($urandom_range(1) == 0) begin
                write_reg(REG_MATRIX_SIZE, size_val);
                if ($urandom_range(3) != 0) begin
                    write_reg(REG_FILL_MODE, CFG_DAT_W'($urandom_range(127)));
                end
            end else begin
                if ($urandom_range(3) != 0) begin
                    write_reg(REG_FILL_MODE, CFG_DAT_W'($urandom_range(127)));
                end
                write_reg(REG_MATRIX_SIZE, size_val);
            end
            if ($urandom_range(9) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DAT_W'($urandom_range(127)));
            end
            run_len = side_n * side_n + $urandom_range(0, side_n * side_n);
            if (run_len > 240) begin
                run_len = $urandom_range(60, 240);
            end
            // stop at the planned item count
            if (run_len > RANDOM_ITEMS + 21 - requests) begin
                run_len = RANDOM_ITEMS + 21 - requests;
            end
            run_cells(run_len);
            phase++;
        end

        s_tvalid <= 1'b0;
        steady   <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d cell requests and %0d register writes across %0d random phases",
                 requests, reg_writes, phase);
        $display("all four fill orders, sizes 0 to 127, restarts and wraps; %0d cells checked",
                 result_count);
        if (error_count == 0) begin
            $display("matrix_fill_order_generator_core regression: pass");
        end else begin
            $display("matrix_fill_order_generator_core regression: fail");
        end
        $finish;
    end

endmodule
